// File: design/sec_pkg.sv
// sec_pkg: shared types and constants for the sound event classifier
// no dependencies

package sec_pkg;

    localparam int PEAK_WINDOW = 4;
    localparam int CNT_W       = $clog2(PEAK_WINDOW + 1);

    localparam logic [19:0] BASE_RESET = 20'd409600;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_LOUD  = 2'd1,
        EV_CLAP  = 2'd2,
        EV_MUSIC = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        CFG_LOUD_RATIO    = 3'd0,
        CFG_BASE_ALPHA    = 3'd1,
        CFG_COOLDOWN      = 3'd2,
        CFG_MUSIC_WINDOW  = 3'd3,
        CFG_CLAP_MIN_GAP  = 3'd4,
        CFG_CLAP_MAX_GAP  = 3'd5,
        CFG_POLL_INTERVAL = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] loud_ratio;
        logic [15:0] baseline_alpha;
        logic [15:0] cooldown_ms;
        logic [15:0] music_window_ms;
        logic [15:0] clap_min_gap_ms;
        logic [15:0] clap_max_gap_ms;
        logic [15:0] poll_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic        accepted;
        event_t      event_res;
        logic [11:0] level;
    } res_t;

endpackage

// File: design/sec_if.sv
// sec_if: valid/ready channel interfaces for samples and results
// depends on sec_pkg

interface sec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic [11:0] sample;

    modport source (output valid, output time_ms, output sample, input ready);
    modport sink (input valid, input time_ms, input sample, output ready);
endinterface

interface sec_out_if;
    import sec_pkg::*;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  event_res;
    logic [11:0] level;

    modport source (output valid, output accepted, output event_res, output level,
                    input ready);
    modport sink (input valid, input accepted, input event_res, input level,
                  output ready);
endinterface

// File: design/sound_event_classifier.sv
// sound_event_classifier: top level with input and result registers
// depends on sec_pkg, sec_if, sec_cfg_regs, sec_core
//
//   channel | direction | transaction payload
//   smp     | in        | time_ms[31:0], sample[11:0]
//   res     | out       | accepted, event_res[1:0], level[11:0]
//   cfg     | in        | cfg_we, cfg_index[2:0], cfg_data[15:0]
//
// one sample per cycle while results are not stalled; samples pass input then result register
// state is updated in the cycle a sample moves from the input register to the result register
// a stalled result holds the input register; the input side keeps taking while it is empty
// rst_n clears both registers' valid flags, all classifier state and the config to defaults

module sound_event_classifier (
    input  logic              clk,
    input  logic              rst_n,
    sec_in_if.sink            smp,
    sec_out_if.source         res,
    input  logic              cfg_we,
    input  sec_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data
);
    import sec_pkg::*;

    cfg_t        cfg;
    res_t        core_res;
    logic        in_valid_reg;
    logic [31:0] in_time_reg;
    logic [11:0] in_sample_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        out_free;
    logic        advance;

    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign smp.ready = !in_valid_reg || out_free;

    sec_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sec_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .time_ms (in_time_reg),
        .sample  (in_sample_reg),
        .cfg     (cfg),
        .result  (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (smp.ready)
            begin
                in_valid_reg <= smp.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp.valid && smp.ready)
        begin
            in_time_reg   <= smp.time_ms;
            in_sample_reg <= smp.sample;
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.accepted  = out_reg.accepted;
    assign res.event_res = out_reg.event_res;
    assign res.level     = out_reg.level;

endmodule

// File: design/sec_cfg_regs.sv
// sec_cfg_regs: configuration register file with write port
// depends on sec_pkg

module sec_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  sec_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data,
    output sec_pkg::cfg_t     cfg
);
    import sec_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loud_ratio       <= 12'd512;
            cfg_reg.baseline_alpha   <= 16'd655;
            cfg_reg.cooldown_ms      <= 16'd150;
            cfg_reg.music_window_ms  <= 16'd3000;
            cfg_reg.clap_min_gap_ms  <= 16'd80;
            cfg_reg.clap_max_gap_ms  <= 16'd600;
            cfg_reg.poll_interval_ms <= 16'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOUD_RATIO:    cfg_reg.loud_ratio       <= cfg_data[11:0];
                CFG_BASE_ALPHA:    cfg_reg.baseline_alpha   <= cfg_data;
                CFG_COOLDOWN:      cfg_reg.cooldown_ms      <= cfg_data;
                CFG_MUSIC_WINDOW:  cfg_reg.music_window_ms  <= cfg_data;
                CFG_CLAP_MIN_GAP:  cfg_reg.clap_min_gap_ms  <= cfg_data;
                CFG_CLAP_MAX_GAP:  cfg_reg.clap_max_gap_ms  <= cfg_data;
                CFG_POLL_INTERVAL: cfg_reg.poll_interval_ms <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/sec_core.sv
// sec_core: classifier state and single-pass sample evaluation
// depends on sec_pkg

module sec_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [31:0]   time_ms,
    input  logic [11:0]   sample,
    input  sec_pkg::cfg_t cfg,
    output sec_pkg::res_t result
);
    import sec_pkg::*;

    logic [19:0]      base_reg;
    logic [19:0]      base_next;
    logic [31:0]      poll_t_reg;
    logic [31:0]      peak_t_reg;
    logic [31:0]      event_t_reg;
    logic [11:0]      level_reg;
    logic [31:0]      peak_times_reg [PEAK_WINDOW];
    logic [CNT_W-1:0] peak_cnt_reg;

    logic [31:0] poll_diff;
    logic [31:0] cool_diff;
    logic [31:0] gap;
    logic [31:0] span;
    logic        take;
    logic        peak;
    logic        fire;
    logic        music;
    logic        clap;
    logic [31:0] thresh;
    logic [16:0] keep_w;
    logic [36:0] keep_prod;
    logic [35:0] add_prod;
    logic [37:0] ema_sum;
    event_t      ev;

    assign poll_diff = time_ms - poll_t_reg;
    assign cool_diff = time_ms - event_t_reg;
    assign gap       = time_ms - peak_t_reg;
    assign span      = time_ms - peak_times_reg[1];

    assign take   = poll_diff >= {16'd0, cfg.poll_interval_ms};
    assign thresh = base_reg * cfg.loud_ratio;
    assign peak   = {4'd0, sample, 16'd0} > thresh;
    assign fire   = take && peak && (cool_diff >= {16'd0, cfg.cooldown_ms});

    assign keep_w    = 17'h10000 - {1'b0, cfg.baseline_alpha};
    assign keep_prod = base_reg * keep_w;
    assign add_prod  = {sample, 8'd0} * cfg.baseline_alpha;
    assign ema_sum   = {1'b0, keep_prod} + {2'd0, add_prod};
    assign base_next = ema_sum[35:16];

    assign music = (peak_cnt_reg >= CNT_W'(PEAK_WINDOW - 1))
                   && (span <= {16'd0, cfg.music_window_ms});
    assign clap  = (gap >= {16'd0, cfg.clap_min_gap_ms})
                   && (gap <= {16'd0, cfg.clap_max_gap_ms});

    always_comb
    begin
        ev = EV_NONE;
        if (fire)
        begin
            priority if (music)
                ev = EV_MUSIC;
            else if (clap)
                ev = EV_CLAP;
            else
                ev = EV_LOUD;
        end
    end

    assign result.accepted  = take;
    assign result.event_res = ev;
    assign result.level     = take ? sample : level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= BASE_RESET;
            poll_t_reg   <= '0;
            peak_t_reg   <= '0;
            event_t_reg  <= '0;
            level_reg    <= '0;
            peak_cnt_reg <= '0;
            for (int i = 0; i < PEAK_WINDOW; i++)
            begin
                peak_times_reg[i] <= '0;
            end
        end
        else if (step && take)
        begin
            poll_t_reg <= time_ms;
            level_reg  <= sample;
            if (!peak)
            begin
                base_reg <= base_next;
            end
            if (fire)
            begin
                peak_t_reg  <= time_ms;
                event_t_reg <= time_ms;
                for (int i = 0; i < PEAK_WINDOW - 1; i++)
                begin
                    peak_times_reg[i] <= peak_times_reg[i + 1];
                end
                peak_times_reg[PEAK_WINDOW - 1] <= time_ms;
                if (peak_cnt_reg < CNT_W'(PEAK_WINDOW))
                begin
                    peak_cnt_reg <= peak_cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: design/sec_checker.sv
// sec_props: port-level checks for sound_event_classifier, bound to the top level
// depends on sec_pkg

module sec_props (
    input logic        clk,
    input logic        rst_n,
    input logic        smp_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_accepted,
    input logic [1:0]  res_event_res,
    input logic [11:0] res_level
);
    import sec_pkg::*;

    logic [11:0] seen_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_level_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            seen_level_reg <= res_level;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(res_accepted) && $stable(res_event_res) && $stable(res_level))
        else $error("result payload changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !smp_ready |-> res_valid && !res_ready)
        else $error("input stalled without a stalled result");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_accepted |->
            res_event_res == EV_NONE && res_level == seen_level_reg)
        else $error("rejected sample changed level or reported an event");

endmodule

bind sound_event_classifier sec_props u_sec_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .smp_ready     (smp.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_accepted  (res.accepted),
    .res_event_res (res.event_res),
    .res_level     (res.level)
);
